// File: rtl/rrpc_pkg.sv
`default_nettype none
package rrpc_pkg;

  localparam int PROCESSES  = 16;
  localparam int RESOURCES  = 4;
  localparam int COUNT_BITS = 8;
  localparam int REQ_FIELDS = 4;
  localparam int PROC_BITS  = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int NEED_BITS  = COUNT_BITS + 1;

  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_SET  = 2'd1;
  localparam logic [1:0] FUNC_REQ  = 2'd2;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_NEED      = 3'd1;
  localparam logic [2:0] STAT_FREE      = 3'd2;
  localparam logic [2:0] STAT_HOLD_WAIT = 3'd3;
  localparam logic [2:0] STAT_ORDER     = 3'd4;
  localparam logic [2:0] STAT_BAD_PROC  = 3'd5;

  localparam logic CFG_RES_IN_USE  = 1'b0;
  localparam logic CFG_PROC_IN_USE = 1'b1;

  typedef struct packed {
    logic [1:0]            func;
    logic [3:0]            process;
    logic [1:0]            resource;
    logic [COUNT_BITS-1:0] held_amount;
    logic [COUNT_BITS-1:0] max_claim;
    logic [COUNT_BITS-1:0] free_amount;
    logic [COUNT_BITS-1:0] req_0;
    logic [COUNT_BITS-1:0] req_1;
    logic [COUNT_BITS-1:0] req_2;
    logic [COUNT_BITS-1:0] req_3;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [1:0] failing_resource;
    logic       granted;
  } out_item_t;

  typedef struct packed {
    logic                  rd_en;
    logic [PROC_BITS-1:0]  rd_addr;
    logic [PROC_BITS-1:0]  wr_addr;
    logic                  ld_en;
    logic                  set_en;
    logic                  commit;
    logic [COUNT_BITS-1:0] req;
    logic [COUNT_BITS-1:0] held_amount;
    logic [COUNT_BITS-1:0] max_claim;
    logic [COUNT_BITS-1:0] free_amount;
  } lane_cmd_t;

  typedef struct packed {
    logic need_fail;
    logic free_fail;
    logic held_nz;
    logic req_nz;
  } lane_flags_t;

  function automatic logic [COUNT_BITS-1:0] req_of(input in_item_t it, input int idx);
    logic [COUNT_BITS-1:0] r;
    case (idx)
      0:       r = it.req_0;
      1:       r = it.req_1;
      2:       r = it.req_2;
      3:       r = it.req_3;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/resource_request_prevention_check.sv
// resource request checker with hold-and-wait and ordering rules
// input channel: in_valid / in_stall with one in_item transaction per item;
//   func selects load of a process entry, set of a free count, or request
// result channel: out_valid / out_stall, exactly one out_item per input item
// config port: cfg_we with cfg_index 0 = resources_in_use,
//   1 = processes_in_use; write only while no item is in flight
// each item takes two cycles: the accept cycle reads the per-resource
//   tables (one registered memory read per lane), the next cycle checks
//   all resource lanes side by side, merges the verdict and writes back
// throughput is one item every two cycles, set by the two-state control:
//   a new item is accepted only after the write-back, so its registered
//   table read always sees the previous item's update
// a finished result sits in the output register, so the next item is
//   accepted while it waits; if the receiver stalls with a result already
//   waiting, the item in the check cycle holds and in_stall stays high
// reset clears the need, held and free tables (valid bits per entry),
//   restores both config registers and empties the output register
`default_nettype none
module resource_request_prevention_check (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire rrpc_pkg::in_item_t   in_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output rrpc_pkg::out_item_t       out_item,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [4:0]           cfg_wdata
);
  import rrpc_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic      state_r, state_nxt;
  in_item_t  item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;
  logic [2:0] res_in_use_r;
  logic [4:0] proc_in_use_r;

  logic in_acc, done, bad_proc, proc_ok;
  logic [RESOURCES-1:0] lane_en;
  lane_cmd_t   [RESOURCES-1:0] cmd;
  lane_flags_t [RESOURCES-1:0] flags;
  out_item_t result;

  assign in_stall  = state_r != ST_IDLE;
  assign in_acc    = in_valid && !in_stall;
  assign done      = (state_r == ST_EXEC) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign proc_ok  = 32'(item_r.process) < PROCESSES;
  assign bad_proc = !proc_ok || ({1'b0, item_r.process} >= proc_in_use_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_EXEC;
      ST_EXEC: if (done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = done || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      res_in_use_r  <= 3'd4;
      proc_in_use_r <= 5'd16;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_RES_IN_USE:  res_in_use_r  <= cfg_wdata[2:0];
          CFG_PROC_IN_USE: proc_in_use_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) item_r <= in_item;
    if (done) out_item_r <= result;
  end

  for (genvar g = 0; g < RESOURCES; g++) begin : g_lane
    assign lane_en[g] = (g < REQ_FIELDS) && (32'(res_in_use_r) > g);

    always_comb begin
      cmd[g].rd_en       = in_acc;
      cmd[g].rd_addr     = PROC_BITS'(in_item.process);
      cmd[g].wr_addr     = PROC_BITS'(item_r.process);
      cmd[g].ld_en       = done && (item_r.func == FUNC_LOAD) && proc_ok &&
                           (32'(item_r.resource) == g);
      cmd[g].set_en      = done && (item_r.func == FUNC_SET) &&
                           (32'(item_r.resource) == g);
      cmd[g].commit      = done && result.granted && lane_en[g];
      cmd[g].req         = req_of(item_r, g);
      cmd[g].held_amount = item_r.held_amount;
      cmd[g].max_claim   = item_r.max_claim;
      cmd[g].free_amount = item_r.free_amount;
    end

    rrpc_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd[g]),
      .flags (flags[g])
    );
  end

  rrpc_merge u_merge (
    .flags    (flags),
    .lane_en  (lane_en),
    .bad_proc (bad_proc),
    .func     (item_r.func),
    .result   (result)
  );

`ifndef SYNTHESIS
  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_EXEC)
    else $error("accepted transaction did not enter the check cycle");

  a_done_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> out_valid_r && state_r == ST_IDLE)
    else $error("finished check did not produce a result");

  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.granted |-> out_item_r.status == STAT_OK)
    else $error("grant with a failing status");

  a_bad_proc_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.status == STAT_BAD_PROC |->
      out_item_r.failing_resource == 2'd0)
    else $error("bad process with a failing resource");

  a_commit_only_grant: assert property (@(posedge clk) disable iff (!rst_n)
    cmd[0].commit |-> done && item_r.func == FUNC_REQ)
    else $error("table update without a granted request");
`endif

endmodule
`default_nettype wire

// File: rtl/rrpc_lane.sv
`default_nettype none
module rrpc_lane (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rrpc_pkg::lane_cmd_t cmd,
  output rrpc_pkg::lane_flags_t   flags
);
  import rrpc_pkg::*;

  logic [NEED_BITS-1:0]  need_mem [PROCESSES];
  logic [COUNT_BITS-1:0] held_mem [PROCESSES];
  logic [PROCESSES-1:0]  vld_r;
  logic [PROCESSES-1:0]  vld_nxt;

  logic [NEED_BITS-1:0]  need_rd_r;
  logic [COUNT_BITS-1:0] held_rd_r;
  logic                  vld_rd_r;
  logic [COUNT_BITS-1:0] free_r;
  logic [COUNT_BITS-1:0] free_nxt;

  logic [NEED_BITS-1:0]  need_cur;
  logic [COUNT_BITS-1:0] held_cur;
  logic [NEED_BITS-1:0]  req_ext;

  assign need_cur = vld_rd_r ? need_rd_r : '0;
  assign held_cur = vld_rd_r ? held_rd_r : '0;
  assign req_ext  = {1'b0, cmd.req};

  assign flags.need_fail = $signed(req_ext) > $signed(need_cur);
  assign flags.free_fail = cmd.req > free_r;
  assign flags.held_nz   = held_cur != '0;
  assign flags.req_nz    = cmd.req != '0;

  always_comb begin
    vld_nxt = vld_r;
    if (cmd.ld_en || cmd.commit) begin
      vld_nxt[cmd.wr_addr] = 1'b1;
    end
    free_nxt = free_r;
    if (cmd.set_en) begin
      free_nxt = cmd.free_amount;
    end else if (cmd.commit) begin
      free_nxt = free_r - cmd.req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      free_r <= '0;
    end else begin
      vld_r  <= vld_nxt;
      free_r <= free_nxt;
    end
  end

  // table storage, one write port and one registered read port each
  always_ff @(posedge clk) begin
    if (cmd.ld_en) begin
      held_mem[cmd.wr_addr] <= cmd.held_amount;
      need_mem[cmd.wr_addr] <= {1'b0, cmd.max_claim} - {1'b0, cmd.held_amount};
    end else if (cmd.commit) begin
      held_mem[cmd.wr_addr] <= held_cur + cmd.req;
      need_mem[cmd.wr_addr] <= need_cur - req_ext;
    end
    if (cmd.rd_en) begin
      need_rd_r <= need_mem[cmd.rd_addr];
      held_rd_r <= held_mem[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_rd_r <= 1'b0;
    end else if (cmd.rd_en) begin
      vld_rd_r <= vld_r[cmd.rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/rrpc_merge.sv
`default_nettype none
module rrpc_merge (
  input  wire rrpc_pkg::lane_flags_t [rrpc_pkg::RESOURCES-1:0] flags,
  input  wire logic [rrpc_pkg::RESOURCES-1:0]                  lane_en,
  input  wire logic                                            bad_proc,
  input  wire logic [1:0]                                      func,
  output rrpc_pkg::out_item_t                                  result
);
  import rrpc_pkg::*;

  always_comb begin
    logic found;
    found  = 1'b0;
    result = '0;
    if (func == FUNC_REQ) begin
      if (bad_proc) begin
        result.status = STAT_BAD_PROC;
        found         = 1'b1;
      end
      // per resource ascending, need before free
      for (int i = 0; i < RESOURCES; i++) begin
        if (!found && lane_en[i] && (flags[i].need_fail || flags[i].free_fail)) begin
          result.status           = flags[i].need_fail ? STAT_NEED : STAT_FREE;
          result.failing_resource = 2'(i);
          found                   = 1'b1;
        end
      end
      for (int i = 0; i < RESOURCES; i++) begin
        if (!found && lane_en[i] && flags[i].held_nz && flags[i].req_nz) begin
          result.status           = STAT_HOLD_WAIT;
          result.failing_resource = 2'(i);
          found                   = 1'b1;
        end
      end
      for (int i = 1; i < RESOURCES; i++) begin
        if (!found && lane_en[i] && flags[i].req_nz && !flags[i-1].req_nz) begin
          result.status           = STAT_ORDER;
          result.failing_resource = 2'(i);
          found                   = 1'b1;
        end
      end
      result.granted = !found;
    end
  end

endmodule
`default_nettype wire

// File: sim/resource_request_prevention_check_test.sv
`timescale 1ns / 100ps

module resource_request_prevention_check_test;
  import rrpc_pkg::*;

  // the block answers this function code with an all-zero result and no table update
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 200;

  class request_ledger;
    int res_cfg;
    int proc_cfg;
    int need_left [PROCESSES][RESOURCES];
    int held_units [PROCESSES][RESOURCES];
    int free_units [RESOURCES];
    out_item_t expected [$];
    int errors;

    function new();
      res_cfg = 4;
      proc_cfg = 16;
      errors = 0;
    endfunction

    function int lanes();
      return (res_cfg > RESOURCES) ? RESOURCES : res_cfg;
    endfunction

    function int procs();
      return (proc_cfg > PROCESSES) ? PROCESSES : proc_cfg;
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function void set_register(logic idx, logic [4:0] val);
      if (idx == CFG_RES_IN_USE) begin
        res_cfg = val & 5'd7;
      end else begin
        proc_cfg = val;
      end
    endfunction

    function out_item_t predict(in_item_t it);
      out_item_t r;
      int amt [4];
      int nr, p, h, m, i;
      r = '0;
      p = it.process;
      amt[0] = it.req_0;
      amt[1] = it.req_1;
      amt[2] = it.req_2;
      amt[3] = it.req_3;
      if (it.func == FUNC_LOAD) begin
        h = it.held_amount;
        m = it.max_claim;
        held_units[p][it.resource] = h;
        need_left[p][it.resource] = m - h;
        return r;
      end
      if (it.func == FUNC_SET) begin
        free_units[it.resource] = it.free_amount;
        return r;
      end
      if (it.func != FUNC_REQ) return r;
      nr = lanes();
      if (p >= procs()) begin
        r.status = STAT_BAD_PROC;
        return r;
      end
      for (i = 0; i < nr; i++) begin
        if (amt[i] > need_left[p][i] || amt[i] > free_units[i]) begin
          r.status = (amt[i] > need_left[p][i]) ? STAT_NEED : STAT_FREE;
          r.failing_resource = 2'(i);
          return r;
        end
      end
      for (i = 0; i < nr; i++) begin
        if (held_units[p][i] > 0 && amt[i] > 0) begin
          r.status = STAT_HOLD_WAIT;
          r.failing_resource = 2'(i);
          return r;
        end
      end
      for (i = 1; i < nr; i++) begin
        if (amt[i] > 0 && amt[i-1] == 0) begin
          r.status = STAT_ORDER;
          r.failing_resource = 2'(i);
          return r;
        end
      end
      for (i = 0; i < nr; i++) begin
        free_units[i] = (free_units[i] - amt[i]) & 255;
        held_units[p][i] = (held_units[p][i] + amt[i]) & 255;
        need_left[p][i] -= amt[i];
      end
      r.status = STAT_OK;
      r.granted = 1'b1;
      return r;
    endfunction

    function void note_input(in_item_t it);
      expected.push_back(predict(it));
    endfunction

    function void compare_field(string field, logic [2:0] want, logic [2:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 40)
          $display("%0t: %s expected %0d got %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: expected no transaction, got status %0d resource %0d granted %0d",
                   $time, got.status, got.failing_resource, got.granted);
        return;
      end
      want = expected.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("failing_resource", want.failing_resource, got.failing_resource);
      compare_field("granted", want.granted, got.granted);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_item;
  logic out_valid;
  logic out_stall;
  out_item_t out_item;
  logic cfg_we;
  logic cfg_index;
  logic [4:0] cfg_wdata;

  bit steady_run;
  request_ledger ledger;
  int phase_res [PHASES] = '{4, 1, 2, 7, 3, 0, 4, 5};
  int phase_proc [PHASES] = '{16, 16, 7, 31, 1, 20, 0, 9};

  resource_request_prevention_check dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= !steady_run && ($urandom_range(99) < 25);
  end

  // results are checked before the new transaction is booked
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) ledger.check_result(out_item);
      if (in_valid && !in_stall) ledger.note_input(in_item);
    end
  end

  function automatic in_item_t pack_item(logic [1:0] f, int p, int r, int h, int m,
                                         int fr, int a0, int a1, int a2, int a3);
    in_item_t it;
    it.func = f;
    it.process = 4'(p);
    it.resource = 2'(r);
    it.held_amount = 8'(h);
    it.max_claim = 8'(m);
    it.free_amount = 8'(fr);
    it.req_0 = 8'(a0);
    it.req_1 = 8'(a1);
    it.req_2 = 8'(a2);
    it.req_3 = 8'(a3);
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int amt [4];
    int roll, nr, np, p, k, i, lim;
    it = in_item_t'({$urandom, $urandom});
    roll = $urandom_range(99);
    if (roll < 4) begin
      it.func = FUNC_UNUSED;
    end else if (roll < 22) begin
      it.func = FUNC_LOAD;
      if ($urandom_range(3) != 0) it.held_amount = '0;
    end else if (roll < 32) begin
      it.func = FUNC_SET;
      if ($urandom_range(1) == 1) it.free_amount = 8'(255 - $urandom_range(15));
    end else if (roll < 80) begin
      // request within need and free on the first lanes, or a lane reload or refill
      it.func = FUNC_REQ;
      nr = ledger.lanes();
      np = ledger.procs();
      p = (np > 0) ? $urandom_range(np - 1) : it.process;
      it.process = 4'(p);
      k = $urandom_range(nr);
      for (i = 0; i < 4; i++) amt[i] = 0;
      for (i = 0; i < k; i++) begin
        if (ledger.held_units[p][i] != 0 && $urandom_range(1) == 1) begin
          it.func = FUNC_LOAD;
          it.resource = 2'(i);
          it.held_amount = '0;
          return it;
        end
        if (ledger.free_units[i] == 0 && $urandom_range(1) == 1) begin
          it.func = FUNC_SET;
          it.resource = 2'(i);
          it.free_amount = 8'($urandom_range(128, 255));
          return it;
        end
        lim = ledger.need_left[p][i];
        if (ledger.free_units[i] < lim) lim = ledger.free_units[i];
        if (lim > 24 && $urandom_range(9) != 0) lim = 24;
        if (lim > 0) amt[i] = $urandom_range(1, lim);
      end
      it.req_0 = 8'(amt[0]);
      it.req_1 = 8'(amt[1]);
      it.req_2 = 8'(amt[2]);
      it.req_3 = 8'(amt[3]);
    end else if (roll < 90) begin
      it.func = FUNC_REQ;
      it.req_0 = 8'($urandom_range(3));
      it.req_1 = 8'($urandom_range(3));
      it.req_2 = 8'($urandom_range(3));
      it.req_3 = 8'($urandom_range(3));
    end else begin
      it.func = FUNC_REQ;
    end
    return it;
  endfunction

  // starts and ends at a falling edge
  task automatic send_item(input in_item_t it);
    while (!steady_run && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (ledger.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_setup(input int res, input int procs_used);
    cfg_we <= 1'b1;
    cfg_index <= CFG_RES_IN_USE;
    cfg_wdata <= 5'(res);
    @(posedge clk);
    ledger.set_register(CFG_RES_IN_USE, 5'(res));
    @(negedge clk);
    cfg_index <= CFG_PROC_IN_USE;
    cfg_wdata <= 5'(procs_used);
    @(posedge clk);
    ledger.set_register(CFG_PROC_IN_USE, 5'(procs_used));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_directed();
    int r;
    // empty tables: a zero request passes, any amount exceeds need
    send_item(pack_item(FUNC_REQ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(pack_item(FUNC_REQ, 0, 0, 0, 0, 0, 1, 0, 0, 0));
    for (r = 0; r < 4; r++) send_item(pack_item(FUNC_SET, 0, r, 0, 0, 255, 0, 0, 0, 0));
    send_item(pack_item(FUNC_LOAD, 1, 0, 0, 255, 0, 0, 0, 0, 0));
    send_item(pack_item(FUNC_LOAD, 1, 1, 0, 10, 0, 0, 0, 0, 0));
    send_item(pack_item(FUNC_LOAD, 1, 2, 0, 255, 0, 0, 0, 0, 0));
    send_item(pack_item(FUNC_REQ, 1, 0, 0, 0, 0, 1, 11, 0, 0));
    send_item(pack_item(FUNC_SET, 0, 2, 0, 0, 0, 0, 0, 0, 0));
    send_item(pack_item(FUNC_REQ, 1, 0, 0, 0, 0, 1, 1, 1, 0));
    send_item(pack_item(FUNC_REQ, 1, 0, 0, 0, 0, 0, 5, 0, 0));
    send_item(pack_item(FUNC_REQ, 1, 0, 0, 0, 0, 255, 10, 0, 0));
    send_item(pack_item(FUNC_REQ, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    // hold and wait on a preloaded held count
    send_item(pack_item(FUNC_SET, 0, 0, 0, 0, 100, 0, 0, 0, 0));
    send_item(pack_item(FUNC_LOAD, 2, 0, 5, 200, 0, 0, 0, 0, 0));
    send_item(pack_item(FUNC_REQ, 2, 0, 0, 0, 0, 1, 0, 0, 0));
    // held above max claim gives a negative need
    send_item(pack_item(FUNC_LOAD, 3, 0, 200, 100, 0, 0, 0, 0, 0));
    send_item(pack_item(FUNC_REQ, 3, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(pack_item(FUNC_LOAD, 15, 3, 255, 255, 0, 0, 0, 0, 0));
    send_item(pack_item(FUNC_UNUSED, 15, 3, 255, 255, 255, 255, 255, 255, 255));
    send_item(pack_item(FUNC_REQ, 15, 3, 255, 255, 255, 0, 0, 0, 255));
  endtask

  initial begin
    int ph, n;
    ledger = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_RES_IN_USE;
    cfg_wdata = '0;
    steady_run = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    run_directed();
    for (ph = 0; ph < PHASES; ph++) begin
      drain();
      write_setup(phase_res[ph], phase_proc[ph]);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        steady_run = (ph == 0 && n >= 40 && n < 160);
        send_item(random_item());
      end
    end
    steady_run = 1'b0;
    drain();
    if (ledger.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
